@@ rtl/gffp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffp_pkg: shared types and constants of the grid first-fit placer
// Holds the field widths, register indexes, sequencer states and the
// control bundle that drives the column fit unit.
// ----------------------------------------------------------------------------
package gffp_pkg;

   localparam int DIM_W            = 5;   // grid size and item size fields
   localparam int ANCHOR_W         = 4;   // anchor column and row fields
   localparam int CMP_W            = 8;   // common width for size compares
   localparam int DEFAULT_MAX_COLS = 16;
   localparam int DEFAULT_MAX_ROWS = 16;
   localparam int REQ_TDATA_W      = 16;
   localparam int RSP_TDATA_W      = 16;
   localparam int CSR_ADDR_W       = 1;

   localparam logic [CSR_ADDR_W-1:0] REG_GRID_COLS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_GRID_ROWS = 1'b1;

   localparam logic [DIM_W-1:0] GRID_RESET = 5'd16;

   localparam logic ACT_CLEAR = 1'b0;
   localparam logic ACT_PLACE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_RESP
   } gffp_state_type;

   typedef struct packed {
      logic start;   // clear column run counters
      logic step;    // fold one occupancy row into the runs
   } gffp_fit_ctl_type;

endpackage

@@ rtl/gffp_occ_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffp_occ_map: occupancy row memory
// One word per grid row, one bit per column. A row valid bit per word lets
// a clear empty the whole map at once; an invalid row reads as free.
// ----------------------------------------------------------------------------
module gffp_occ_map #(
   parameter int MAX_COLS = gffp_pkg::DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = gffp_pkg::DEFAULT_MAX_ROWS,
   parameter int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                rd_en,
   input  logic [ROW_AW-1:0]   rd_addr,
   output logic [MAX_COLS-1:0] rd_data,
   input  logic                wr_en,
   input  logic [ROW_AW-1:0]   wr_addr,
   input  logic [MAX_COLS-1:0] wr_data
);
   import gffp_pkg::*;

   logic [MAX_COLS-1:0] mem [MAX_ROWS];
   logic [MAX_ROWS-1:0] row_valid_ff;
   logic [MAX_COLS-1:0] rd_word_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (clear) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

@@ rtl/gffp_fit_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffp_fit_unit: shared column fit unit
// Keeps a free-run height per column over the rows seen so far. After each
// row it finds the leftmost column where item_w adjacent columns have been
// free for at least item_h rows, which places an anchor ending at that row.
// ----------------------------------------------------------------------------
module gffp_fit_unit #(
   parameter int MAX_COLS = gffp_pkg::DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = gffp_pkg::DEFAULT_MAX_ROWS,
   parameter int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   parameter int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   parameter int COL_CW   = $clog2(MAX_COLS + 1),
   parameter int RUN_W    = $clog2(MAX_ROWS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gffp_pkg::gffp_fit_ctl_type    ctl,
   input  logic [MAX_COLS-1:0]           row_bits,
   input  logic [ROW_AW-1:0]             row_tag,
   input  logic [COL_CW-1:0]             cols,
   input  logic [gffp_pkg::DIM_W-1:0]    item_w,
   input  logic [gffp_pkg::DIM_W-1:0]    item_h,
   output logic                          fit_valid,
   output logic                          fit_found,
   output logic [COL_AW-1:0]             fit_col,
   output logic [ROW_AW-1:0]             fit_row
);
   import gffp_pkg::*;

   logic [RUN_W-1:0]    run_ff [MAX_COLS];
   logic [RUN_W-1:0]    run_in [MAX_COLS];
   logic [MAX_COLS-1:0] free_ff;
   logic [MAX_COLS-1:0] free_in;
   logic                free_v_ff;
   logic [ROW_AW-1:0]   tag_ff;
   logic [MAX_COLS-1:0] win_mask;
   logic [MAX_COLS-1:0] fit_vec;

   // Columns past the grid count as occupied, so no window reaches them.
   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         if (row_bits[c] || (CMP_W'(c) >= CMP_W'(cols))) begin
            run_in[c] = '0;
         end else if (CMP_W'(run_ff[c]) >= CMP_W'(MAX_ROWS)) begin
            run_in[c] = run_ff[c];
         end else begin
            run_in[c] = run_ff[c] + RUN_W'(1);
         end
         free_in[c] = CMP_W'(run_in[c]) >= CMP_W'(item_h);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         for (int c = 0; c < MAX_COLS; c++) begin
            run_ff[c] <= '0;
         end
      end else if (ctl.step) begin
         run_ff  <= run_in;
         free_ff <= free_in;
         tag_ff  <= row_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_v_ff <= 1'b0;
      end else begin
         free_v_ff <= ctl.step && !ctl.start;
      end
   end

   // Window test per column; bits shifted in from beyond the map are zero.
   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         win_mask[c] = CMP_W'(c) < CMP_W'(item_w);
      end
      for (int c = 0; c < MAX_COLS; c++) begin
         fit_vec[c] = ((free_ff >> c) & win_mask) == win_mask;
      end
      fit_col = '0;
      for (int c = MAX_COLS - 1; c >= 0; c--) begin
         if (fit_vec[c]) begin
            fit_col = COL_AW'(c);
         end
      end
   end

   assign fit_valid = free_v_ff;
   assign fit_found = free_v_ff && (|fit_vec);
   assign fit_row   = tag_ff;

endmodule

@@ rtl/grid_first_fit_placer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_first_fit_placer: first-fit rectangle placement on an occupancy grid
// Takes clear and place beats, returns one result beat per request.
// ----------------------------------------------------------------------------
// A clear beat (tuser 0) empties the occupancy map and answers not placed;
// its result passes the respond state into the output register. A place
// beat (tuser 1) scans the grid one row per cycle, reading the row memory and
// folding each row into a shared column fit unit that tracks how long each
// column has been free; the first row at which a wide enough free window has
// been open for item_height rows gives the topmost, then leftmost, anchor.
// The rectangle's rows are then marked by read-modify-write, one row per
// cycle, and a final step drains the last write. The row memory has a
// single read port, which sets the pace of both the scan and the marking.
// Requests with a zero size or a size beyond the configured grid answer not
// placed through the respond state, like a clear. The block takes its next
// request the cycle after a result is loaded into the output register, and
// holds off while a finished result waits for that register. Write grid_cols
// and grid_rows only while no request is in flight; values above MAX_COLS or
// MAX_ROWS act as the maximum. Reset empties the map at once, with no
// clearing pass.
// ----------------------------------------------------------------------------
module grid_first_fit_placer #(
   parameter int MAX_COLS = gffp_pkg::DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = gffp_pkg::DEFAULT_MAX_ROWS
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_we,
   input  logic [gffp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gffp_pkg::DIM_W-1:0]         csr_wdata,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gffp_pkg::REQ_TDATA_W-1:0]   req_tdata,  // item_width[4:0], item_height[9:5]
   input  logic                               req_tuser,  // action
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gffp_pkg::RSP_TDATA_W-1:0]   rsp_tdata   // placed[0], anchor_col[4:1],
                                                          // anchor_row[8:5]
);
   import gffp_pkg::*;

   localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int COL_CW = $clog2(MAX_COLS + 1);
   localparam int ROW_CW = $clog2(MAX_ROWS + 1);

   // configuration registers
   logic [DIM_W-1:0]    grid_cols_ff;
   logic [DIM_W-1:0]    grid_rows_ff;
   logic [COL_CW-1:0]   cols_cl;
   logic [ROW_CW-1:0]   rows_cl;

   // sequencer
   gffp_state_type      state_ff, state_in;
   logic [DIM_W-1:0]    item_w_ff, item_w_in;
   logic [DIM_W-1:0]    item_h_ff, item_h_in;
   logic [ROW_CW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic                rd_v_ff, rd_v_in;
   logic [ROW_AW-1:0]   rd_row_ff, rd_row_in;
   logic [COL_AW-1:0]   anchor_col_ff, anchor_col_in;
   logic [ROW_AW-1:0]   anchor_row_ff, anchor_row_in;
   logic [MAX_COLS-1:0] mark_mask_ff, mark_mask_in;
   logic [ROW_CW-1:0]   mk_cnt_ff, mk_cnt_in;
   logic                res_placed_ff, res_placed_in;
   logic [ANCHOR_W-1:0] res_col_ff, res_col_in;
   logic [ANCHOR_W-1:0] res_row_ff, res_row_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // request fields
   logic [DIM_W-1:0]    req_w;
   logic [DIM_W-1:0]    req_h;
   logic                req_fire;
   logic                size_ok;

   // memory and fit unit hookup
   logic                occ_clear;
   logic                occ_rd_en;
   logic [ROW_AW-1:0]   occ_rd_addr;
   logic [MAX_COLS-1:0] occ_rd_data;
   logic                occ_wr_en;
   logic [ROW_AW-1:0]   occ_wr_addr;
   logic [MAX_COLS-1:0] occ_wr_data;
   gffp_fit_ctl_type    fit_ctl;
   logic                fit_valid;
   logic                fit_found;
   logic [COL_AW-1:0]   fit_col;
   logic [ROW_AW-1:0]   fit_row;

   assign req_w    = req_tdata[DIM_W-1:0];
   assign req_h    = req_tdata[2*DIM_W-1:DIM_W];
   // Ready is high exactly in the idle state.
   assign req_fire = req_tvalid && (state_ff == ST_IDLE);

   // Clamp the configured size to the map.
   assign cols_cl = (CMP_W'(grid_cols_ff) > CMP_W'(MAX_COLS)) ? COL_CW'(MAX_COLS)
                                                              : COL_CW'(grid_cols_ff);
   assign rows_cl = (CMP_W'(grid_rows_ff) > CMP_W'(MAX_ROWS)) ? ROW_CW'(MAX_ROWS)
                                                              : ROW_CW'(grid_rows_ff);

   assign size_ok = (req_w != '0) && (req_h != '0) &&
                    (CMP_W'(req_w) <= CMP_W'(cols_cl)) &&
                    (CMP_W'(req_h) <= CMP_W'(rows_cl));

   // Configuration writes; an index past the list has no effect.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_RESET;
         grid_rows_ff <= GRID_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_GRID_COLS: grid_cols_ff <= csr_wdata;
            REG_GRID_ROWS: grid_rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_w_ff     <= item_w_in;
      item_h_ff     <= item_h_in;
      rd_ptr_ff     <= rd_ptr_in;
      rd_row_ff     <= rd_row_in;
      anchor_col_ff <= anchor_col_in;
      anchor_row_ff <= anchor_row_in;
      mark_mask_ff  <= mark_mask_in;
      mk_cnt_ff     <= mk_cnt_in;
      res_placed_ff <= res_placed_in;
      res_col_ff    <= res_col_in;
      res_row_ff    <= res_row_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      item_w_in     = item_w_ff;
      item_h_in     = item_h_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_v_in       = 1'b0;
      rd_row_in     = rd_row_ff;
      anchor_col_in = anchor_col_ff;
      anchor_row_in = anchor_row_ff;
      mark_mask_in  = mark_mask_ff;
      mk_cnt_in     = mk_cnt_ff;
      res_placed_in = res_placed_ff;
      res_col_in    = res_col_ff;
      res_row_in    = res_row_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      req_tready    = 1'b0;
      occ_clear     = 1'b0;
      occ_rd_en     = 1'b0;
      occ_rd_addr   = '0;
      occ_wr_en     = 1'b0;
      occ_wr_addr   = '0;
      occ_wr_data   = occ_rd_data | mark_mask_ff;
      fit_ctl       = '0;

      // Drop the result beat once taken; a new one may replace it below.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               item_w_in     = req_w;
               item_h_in     = req_h;
               res_placed_in = 1'b0;
               res_col_in    = '0;
               res_row_in    = '0;
               rd_ptr_in     = '0;
               fit_ctl.start = 1'b1;
               if (req_tuser == ACT_CLEAR) begin
                  occ_clear = 1'b1;
                  state_in  = ST_RESP;
               end else if (size_ok) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_SCAN: begin
            // Issue one row read per cycle; fold each returned row into the runs.
            if (CMP_W'(rd_ptr_ff) < CMP_W'(rows_cl)) begin
               occ_rd_en   = 1'b1;
               occ_rd_addr = ROW_AW'(rd_ptr_ff);
               rd_v_in     = 1'b1;
               rd_row_in   = ROW_AW'(rd_ptr_ff);
               rd_ptr_in   = rd_ptr_ff + ROW_CW'(1);
            end
            fit_ctl.step = rd_v_ff;
            if (fit_found) begin
               // Window ends at fit_row; its top row is item_h - 1 above.
               anchor_col_in = fit_col;
               anchor_row_in = ROW_AW'(CMP_W'(fit_row) + CMP_W'(1) - CMP_W'(item_h_ff));
               for (int c = 0; c < MAX_COLS; c++) begin
                  mark_mask_in[c] = (CMP_W'(c) >= CMP_W'(fit_col)) &&
                                    (CMP_W'(c) < CMP_W'(fit_col) + CMP_W'(item_w_ff));
               end
               mk_cnt_in = '0;
               rd_v_in   = 1'b0;
               state_in  = ST_MARK;
            end else if (fit_valid &&
                         (CMP_W'(fit_row) + CMP_W'(1) == CMP_W'(rows_cl))) begin
               rd_v_in  = 1'b0;
               state_in = ST_RESP;
            end
         end

         ST_MARK: begin
            // Read row k while writing back row k-1 with the mask set.
            if (CMP_W'(mk_cnt_ff) < CMP_W'(item_h_ff)) begin
               occ_rd_en   = 1'b1;
               occ_rd_addr = ROW_AW'(CMP_W'(anchor_row_ff) + CMP_W'(mk_cnt_ff));
            end
            if (mk_cnt_ff != '0) begin
               occ_wr_en   = 1'b1;
               occ_wr_addr = ROW_AW'(CMP_W'(anchor_row_ff) + CMP_W'(mk_cnt_ff) - CMP_W'(1));
            end
            mk_cnt_in = mk_cnt_ff + ROW_CW'(1);
            if (CMP_W'(mk_cnt_ff) == CMP_W'(item_h_ff)) begin
               res_placed_in = 1'b1;
               res_col_in    = ANCHOR_W'(CMP_W'(anchor_col_ff));
               res_row_in    = ANCHOR_W'(CMP_W'(anchor_row_ff));
               state_in      = ST_RESP;
            end
         end

         ST_RESP: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({res_row_ff, res_col_ff, res_placed_ff});
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   gffp_occ_map #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .ROW_AW   (ROW_AW)
   ) u_occ_map (
      .clock    (clock),
      .reset    (reset),
      .clear    (occ_clear),
      .rd_en    (occ_rd_en),
      .rd_addr  (occ_rd_addr),
      .rd_data  (occ_rd_data),
      .wr_en    (occ_wr_en),
      .wr_addr  (occ_wr_addr),
      .wr_data  (occ_wr_data)
   );

   gffp_fit_unit #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .ROW_AW   (ROW_AW),
      .COL_AW   (COL_AW),
      .COL_CW   (COL_CW),
      .RUN_W    (ROW_CW)
   ) u_fit_unit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fit_ctl),
      .row_bits  (occ_rd_data),
      .row_tag   (rd_row_ff),
      .cols      (cols_cl),
      .item_w    (item_w_ff),
      .item_h    (item_h_ff),
      .fit_valid (fit_valid),
      .fit_found (fit_found),
      .fit_col   (fit_col),
      .fit_row   (fit_row)
   );

endmodule
